/* hdl/sss_pkg.sv */
`default_nettype none
package sss_pkg;

  typedef enum logic [2:0] {
    FUNC_POWER_ON   = 3'd0,
    FUNC_POWER_OFF  = 3'd1,
    FUNC_GRIP_OPEN  = 3'd2,
    FUNC_GRIP_CLOSE = 3'd3,
    FUNC_TRAY_OPEN  = 3'd4,
    FUNC_TRAY_CLOSE = 3'd5,
    FUNC_ARM_MOVE   = 3'd6,
    FUNC_MS_TICK    = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    REG_SETTLE_MS      = 3'd0,
    REG_GRIP_OPEN_STEP = 3'd1,
    REG_GRIP_CLOSE_STEP = 3'd2,
    REG_TRAY_STEP      = 3'd3,
    REG_ARM_RAISE_STEP = 3'd4,
    REG_ARM_LOWER_STEP = 3'd5
  } reg_idx_t;

  localparam logic [7:0]  GRIP_OPEN_LIMIT  = 8'd14;
  localparam logic [7:0]  GRIP_CLOSE_LIMIT = 8'd36;
  localparam logic [7:0]  GRIP_SPAN        = 8'd22;
  localparam logic [7:0]  TRAY_CLOSE_LIMIT = 8'd9;
  localparam logic [7:0]  TRAY_OPEN_LIMIT  = 8'd24;
  localparam logic [7:0]  TRAY_SPAN        = 8'd15;
  localparam logic [7:0]  ARM_RIGHT_RESET  = 8'd39;
  localparam logic [7:0]  ARM_LEFT_RESET   = 8'd3;
  localparam logic [7:0]  ARM_PAIR_SUM     = 8'd42;
  localparam logic [6:0]  PCT_MAX          = 7'd100;
  localparam logic [15:0] ARM_SLOPE_H      = 16'd29;
  localparam logic [15:0] ARM_BASE_H       = 16'd1000;
  localparam logic [15:0] HUNDRED          = 16'd100;
  localparam logic [15:0] MS_MAX           = 16'hFFFF;

  localparam logic [15:0] SETTLE_RESET     = 16'd300;
  localparam logic [15:0] GRIP_OPEN_RESET  = 16'd15;
  localparam logic [15:0] GRIP_CLOSE_RESET = 16'd20;
  localparam logic [15:0] TRAY_STEP_RESET  = 16'd20;
  localparam logic [15:0] ARM_RAISE_RESET  = 16'd30;
  localparam logic [15:0] ARM_LOWER_RESET  = 16'd40;

  typedef struct packed {
    logic [15:0] settle_ms;
    logic [15:0] grip_open_step_ms;
    logic [15:0] grip_close_step_ms;
    logic [15:0] tray_step_ms;
    logic [15:0] arm_raise_step_ms;
    logic [15:0] arm_lower_step_ms;
  } cfg_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] grip;
    logic [7:0] tray;
    logic [7:0] arm_right;
    logic [7:0] arm_left;
    logic       power;
  } result_t;

endpackage
`default_nettype wire

/* hdl/sss_core.sv */
`default_nettype none
module sss_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step_en,
  input  wire sss_pkg::func_t func,
  input  wire logic [6:0]     pct_raw,
  input  wire sss_pkg::cfg_t  cfg,
  output sss_pkg::result_t    res
);

  logic        grip_closed_flag, tray_open_flag;
  logic [7:0]  grip_level, tray_level, arm_right_level, arm_left_level;
  logic        entry_phase, timer_armed, hold_power, power_out;
  logic [15:0] elapsed_ms;

  logic        grip_closed_flag_next, tray_open_flag_next;
  logic [7:0]  grip_level_next, tray_level_next, arm_right_level_next, arm_left_level_next;
  logic        entry_phase_next, timer_armed_next, hold_power_next, power_out_next;
  logic [15:0] elapsed_ms_next;
  logic        busy;

  logic [6:0]         pct;
  logic [15:0]        right_h;
  logic [15:0]        target_h;
  logic signed [16:0] diff_h;
  logic               arm_raise, arm_lower;

  // arm target in hundredths: 29*p + 1000
  always_comb begin
    pct      = (pct_raw > sss_pkg::PCT_MAX) ? sss_pkg::PCT_MAX : pct_raw;
    right_h  = 16'({8'd0, arm_right_level} * sss_pkg::HUNDRED);
    target_h = 16'({9'd0, pct} * sss_pkg::ARM_SLOPE_H) + sss_pkg::ARM_BASE_H;
    diff_h   = $signed({1'b0, right_h}) - $signed({1'b0, target_h});
    arm_raise = (diff_h <= -17'sd100);
    arm_lower = (diff_h >= 17'sd100);
  end

  always_comb begin
    logic settle_busy;
    logic motion;
    settle_busy           = 1'b0;
    motion                = 1'b0;
    grip_closed_flag_next = grip_closed_flag;
    tray_open_flag_next   = tray_open_flag;
    grip_level_next       = grip_level;
    tray_level_next       = tray_level;
    arm_right_level_next  = arm_right_level;
    arm_left_level_next   = arm_left_level;
    entry_phase_next      = entry_phase;
    timer_armed_next      = timer_armed;
    hold_power_next       = hold_power;
    power_out_next        = power_out;
    elapsed_ms_next       = elapsed_ms;
    busy                  = 1'b0;

    case (func)
      sss_pkg::FUNC_POWER_ON: begin
        hold_power_next = 1'b1;
        power_out_next  = 1'b1;
      end
      sss_pkg::FUNC_POWER_OFF: begin
        hold_power_next = 1'b0;
        power_out_next  = 1'b0;
      end
      sss_pkg::FUNC_MS_TICK: begin
        if (elapsed_ms != sss_pkg::MS_MAX) elapsed_ms_next = elapsed_ms + 16'd1;
      end
      default: motion = 1'b1;
    endcase

    // settle phase: load compare, wait, then enable power
    if (motion && entry_phase) begin
      if (timer_armed) begin
        if (func == sss_pkg::FUNC_GRIP_OPEN || func == sss_pkg::FUNC_GRIP_CLOSE)
          grip_level_next = grip_closed_flag ? (sss_pkg::GRIP_SPAN + sss_pkg::GRIP_OPEN_LIMIT)
                                             : sss_pkg::GRIP_OPEN_LIMIT;
        else if (func == sss_pkg::FUNC_TRAY_OPEN || func == sss_pkg::FUNC_TRAY_CLOSE)
          tray_level_next = tray_open_flag ? (sss_pkg::TRAY_SPAN + sss_pkg::TRAY_CLOSE_LIMIT)
                                           : sss_pkg::TRAY_CLOSE_LIMIT;
        elapsed_ms_next  = 16'd0;
        timer_armed_next = 1'b0;
      end
      if (elapsed_ms_next >= cfg.settle_ms) begin
        power_out_next   = 1'b1;
        entry_phase_next = 1'b0;
        timer_armed_next = 1'b1;
        elapsed_ms_next  = 16'd0;
      end else begin
        settle_busy = 1'b1;
      end
    end

    if (motion && settle_busy) begin
      busy = 1'b1;
    end else if (motion) begin
      case (func)
        sss_pkg::FUNC_GRIP_OPEN: begin
          if (grip_level_next > sss_pkg::GRIP_OPEN_LIMIT) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.grip_open_step_ms) begin
              elapsed_ms_next = 16'd0;
              grip_level_next = grip_level_next - 8'd1;
            end
          end else begin
            grip_closed_flag_next = 1'b0;
            entry_phase_next      = 1'b1;
            if (!hold_power) power_out_next = 1'b0;
          end
        end
        sss_pkg::FUNC_GRIP_CLOSE: begin
          if (grip_level_next < sss_pkg::GRIP_CLOSE_LIMIT) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.grip_close_step_ms) begin
              elapsed_ms_next = 16'd0;
              grip_level_next = grip_level_next + 8'd1;
            end
          end else begin
            grip_closed_flag_next = 1'b1;
            entry_phase_next      = 1'b1;
            if (!hold_power) power_out_next = 1'b0;
          end
        end
        sss_pkg::FUNC_TRAY_OPEN: begin
          if (tray_level_next < sss_pkg::TRAY_OPEN_LIMIT) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.tray_step_ms) begin
              elapsed_ms_next = 16'd0;
              tray_level_next = tray_level_next + 8'd1;
            end
          end else begin
            tray_open_flag_next = 1'b1;
            entry_phase_next    = 1'b1;
            if (!hold_power) power_out_next = 1'b0;
          end
        end
        sss_pkg::FUNC_TRAY_CLOSE: begin
          if (tray_level_next > sss_pkg::TRAY_CLOSE_LIMIT) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.tray_step_ms) begin
              elapsed_ms_next = 16'd0;
              tray_level_next = tray_level_next - 8'd1;
            end
          end else begin
            tray_open_flag_next = 1'b0;
            entry_phase_next    = 1'b1;
            if (!hold_power) power_out_next = 1'b0;
          end
        end
        default: begin
          // arm move; the left servo mirrors the right one
          if (arm_raise) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.arm_raise_step_ms) begin
              elapsed_ms_next      = 16'd0;
              arm_right_level_next = arm_right_level + 8'd1;
              arm_left_level_next  = arm_left_level - 8'd1;
            end
          end else if (arm_lower) begin
            busy = 1'b1;
            if (elapsed_ms_next >= cfg.arm_lower_step_ms) begin
              elapsed_ms_next      = 16'd0;
              arm_right_level_next = arm_right_level - 8'd1;
              arm_left_level_next  = arm_left_level + 8'd1;
            end
          end else begin
            entry_phase_next = 1'b1;
            if (!hold_power) power_out_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grip_closed_flag <= 1'b0;
      tray_open_flag   <= 1'b0;
      grip_level       <= sss_pkg::GRIP_OPEN_LIMIT;
      tray_level       <= sss_pkg::TRAY_CLOSE_LIMIT;
      arm_right_level  <= sss_pkg::ARM_RIGHT_RESET;
      arm_left_level   <= sss_pkg::ARM_LEFT_RESET;
      entry_phase      <= 1'b1;
      timer_armed      <= 1'b1;
      hold_power       <= 1'b0;
      power_out        <= 1'b0;
      elapsed_ms       <= 16'd0;
    end else if (step_en) begin
      grip_closed_flag <= grip_closed_flag_next;
      tray_open_flag   <= tray_open_flag_next;
      grip_level       <= grip_level_next;
      tray_level       <= tray_level_next;
      arm_right_level  <= arm_right_level_next;
      arm_left_level   <= arm_left_level_next;
      entry_phase      <= entry_phase_next;
      timer_armed      <= timer_armed_next;
      hold_power       <= hold_power_next;
      power_out        <= power_out_next;
      elapsed_ms       <= elapsed_ms_next;
    end
  end

  always_comb begin
    res.busy      = busy;
    res.grip      = grip_level_next;
    res.tray      = tray_level_next;
    res.arm_right = arm_right_level_next;
    res.arm_left  = arm_left_level_next;
    res.power     = power_out_next;
  end

endmodule
`default_nettype wire

/* hdl/servo_slew_sequencer_top.sv */
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------------------------------
// request   | req_valid, req_stall  | func, arm_target_percent
// result    | rsp_valid, rsp_stall  | busy_res, grip_compare, tray_compare,
//           |                       | arm_right_compare, arm_left_compare, servo_power
// config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled. Each request passes from the
// request register through one pass of step logic into the result register; state
// updates as the request moves into the result register.
// rst is synchronous, active high; it restores the register defaults and servo state.
// A full request register with a stalled result raises req_stall; otherwise requests
// keep flowing while a result waits. Config writes are always ready.
`default_nettype none
module servo_slew_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [2:0] func,
  input  wire logic [6:0] arm_target_percent,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            busy_res,
  output logic [7:0]      grip_compare,
  output logic [7:0]      tray_compare,
  output logic [7:0]      arm_right_compare,
  output logic [7:0]      arm_left_compare,
  output logic            servo_power,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  // request register
  logic            s1_valid;
  sss_pkg::func_t  s1_func;
  logic [6:0]      s1_pct;

  sss_pkg::cfg_t    cfg;
  sss_pkg::result_t res;

  logic req_take;
  logic advance;

  // advance the request register into the result register when it is free
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // hold the payload unless a new request lands
  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_func <= sss_pkg::func_t'(func);
      s1_pct  <= arm_target_percent;
    end
  end

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms          <= sss_pkg::SETTLE_RESET;
      cfg.grip_open_step_ms  <= sss_pkg::GRIP_OPEN_RESET;
      cfg.grip_close_step_ms <= sss_pkg::GRIP_CLOSE_RESET;
      cfg.tray_step_ms       <= sss_pkg::TRAY_STEP_RESET;
      cfg.arm_raise_step_ms  <= sss_pkg::ARM_RAISE_RESET;
      cfg.arm_lower_step_ms  <= sss_pkg::ARM_LOWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sss_pkg::reg_idx_t'(cfg_index))
        sss_pkg::REG_SETTLE_MS:       cfg.settle_ms          <= cfg_data;
        sss_pkg::REG_GRIP_OPEN_STEP:  cfg.grip_open_step_ms  <= cfg_data;
        sss_pkg::REG_GRIP_CLOSE_STEP: cfg.grip_close_step_ms <= cfg_data;
        sss_pkg::REG_TRAY_STEP:       cfg.tray_step_ms       <= cfg_data;
        sss_pkg::REG_ARM_RAISE_STEP:  cfg.arm_raise_step_ms  <= cfg_data;
        sss_pkg::REG_ARM_LOWER_STEP:  cfg.arm_lower_step_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // step logic and servo state; state commits as the request advances
  sss_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .func    (s1_func),
    .pct_raw (s1_pct),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      busy_res          <= res.busy;
      grip_compare      <= res.grip;
      tray_compare      <= res.tray;
      arm_right_compare <= res.arm_right;
      arm_left_compare  <= res.arm_left;
      servo_power       <= res.power;
    end
  end

  // a stall towards the requester only ever comes from a full pipe
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled with a free slot");

  a_grip_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (grip_compare >= sss_pkg::GRIP_OPEN_LIMIT &&
                   grip_compare <= sss_pkg::GRIP_CLOSE_LIMIT))
    else $error("gripper compare out of range");

  a_tray_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (tray_compare >= sss_pkg::TRAY_CLOSE_LIMIT &&
                   tray_compare <= sss_pkg::TRAY_OPEN_LIMIT))
    else $error("tray compare out of range");

  a_arm_mirror: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (8'(arm_right_compare + arm_left_compare) == sss_pkg::ARM_PAIR_SUM))
    else $error("arm pair no longer mirrored");

endmodule
`default_nettype wire

/* tb/tb_servo_slew_sequencer_top.sv */
`default_nettype none
module tb_servo_slew_sequencer_top;
  import sss_pkg::*;

  // Quiet cycles (no request, result or register write accepted) before giving up.
  localparam int QUIET_LIMIT   = 1000;
  // Cycles to linger once the last expected result is in.
  localparam int TAIL_CYCLES   = 4;
  // Random part: number of requests to send after the directed tests.
  localparam int RANDOM_ITEMS  = 640;
  // Upper bound of polls for one motion before moving on.
  localparam int MAX_POLLS     = 400;

  typedef enum int {GRP_GRIP, GRP_TRAY, GRP_ARM} servo_group_t;

  // Clock and reset; every input starts at a known value.
  logic        clk                = 1'b0;
  logic        rst                = 1'b1;
  logic        req_valid          = 1'b0;
  logic [2:0]  func               = '0;
  logic [6:0]  arm_target_percent = '0;
  logic        rsp_stall          = 1'b0;
  logic        cfg_valid          = 1'b0;
  logic [2:0]  cfg_index          = '0;
  logic [15:0] cfg_data           = '0;

  logic        req_stall;
  logic        rsp_valid;
  logic        busy_res;
  logic [7:0]  grip_compare;
  logic [7:0]  tray_compare;
  logic [7:0]  arm_right_compare;
  logic [7:0]  arm_left_compare;
  logic        servo_power;
  logic        cfg_ready;

  servo_slew_sequencer_top uut (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .func              (func),
    .arm_target_percent(arm_target_percent),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .busy_res          (busy_res),
    .grip_compare      (grip_compare),
    .tray_compare      (tray_compare),
    .arm_right_compare (arm_right_compare),
    .arm_left_compare  (arm_left_compare),
    .servo_power       (servo_power),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Servo sequencer model: our own copy of the timing registers and the
  // sequencer state, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  cfg_t        cfg_m;
  logic        grip_closed;
  logic        tray_open;
  logic [7:0]  grip_lvl;
  logic [7:0]  tray_lvl;
  logic [7:0]  arm_r;
  logic [7:0]  arm_l;
  logic        settling;      // still in the load-and-settle phase
  logic        settle_armed;  // next poll reloads the compare and restarts the count
  logic        hold_pwr;
  logic        pwr;
  logic [15:0] ms_count;

  // Predicted outputs waiting for the block to produce them, oldest first.
  result_t     servo_outputs_q[$];
  logic        last_busy;
  int          items_sent  = 0;
  int          errors      = 0;

  // Sender burst shaping and receiver stall pattern.
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  function automatic void reset_servo_model();
    cfg_m.settle_ms          = SETTLE_RESET;
    cfg_m.grip_open_step_ms  = GRIP_OPEN_RESET;
    cfg_m.grip_close_step_ms = GRIP_CLOSE_RESET;
    cfg_m.tray_step_ms       = TRAY_STEP_RESET;
    cfg_m.arm_raise_step_ms  = ARM_RAISE_RESET;
    cfg_m.arm_lower_step_ms  = ARM_LOWER_RESET;
    grip_closed  = 1'b0;
    tray_open    = 1'b0;
    grip_lvl     = GRIP_OPEN_LIMIT;
    tray_lvl     = TRAY_CLOSE_LIMIT;
    arm_r        = ARM_RIGHT_RESET;
    arm_l        = ARM_LEFT_RESET;
    settling     = 1'b1;
    settle_armed = 1'b1;
    hold_pwr     = 1'b0;
    pwr          = 1'b0;
    ms_count     = '0;
  endfunction

  // Load the compare on the first poll, then hold busy until the settle
  // time has run out; power comes on as the settle phase ends.
  function automatic bit settle_pending(input servo_group_t grp);
    if (!settling) return 1'b0;
    if (settle_armed) begin
      if (grp == GRP_GRIP)
        grip_lvl = grip_closed ? GRIP_CLOSE_LIMIT : GRIP_OPEN_LIMIT;
      else if (grp == GRP_TRAY)
        tray_lvl = tray_open ? TRAY_OPEN_LIMIT : TRAY_CLOSE_LIMIT;
      ms_count     = '0;
      settle_armed = 1'b0;
    end
    if (ms_count >= cfg_m.settle_ms) begin
      pwr          = 1'b1;
      settling     = 1'b0;
      settle_armed = 1'b1;
      ms_count     = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit interval_due(input logic [15:0] interval);
    if (ms_count >= interval) begin
      ms_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void end_motion();
    settling = 1'b1;
    if (!hold_pwr) pwr = 1'b0;
  endfunction

  function automatic result_t servo_step(input func_t op, input logic [6:0] pct_raw);
    result_t r;
    int      pct;
    int      offset_h;
    logic    busy;
    pct  = (pct_raw > PCT_MAX) ? int'(PCT_MAX) : int'(pct_raw);
    busy = 1'b0;
    case (op)
      FUNC_POWER_ON: begin
        hold_pwr = 1'b1;
        pwr      = 1'b1;
      end
      FUNC_POWER_OFF: begin
        hold_pwr = 1'b0;
        pwr      = 1'b0;
      end
      FUNC_GRIP_OPEN: begin
        if (settle_pending(GRP_GRIP)) busy = 1'b1;
        else if (grip_lvl > GRIP_OPEN_LIMIT) begin
          if (interval_due(cfg_m.grip_open_step_ms)) grip_lvl = grip_lvl - 8'd1;
          busy = 1'b1;
        end else begin
          grip_closed = 1'b0;
          end_motion();
        end
      end
      FUNC_GRIP_CLOSE: begin
        if (settle_pending(GRP_GRIP)) busy = 1'b1;
        else if (grip_lvl < GRIP_CLOSE_LIMIT) begin
          if (interval_due(cfg_m.grip_close_step_ms)) grip_lvl = grip_lvl + 8'd1;
          busy = 1'b1;
        end else begin
          grip_closed = 1'b1;
          end_motion();
        end
      end
      FUNC_TRAY_OPEN: begin
        if (settle_pending(GRP_TRAY)) busy = 1'b1;
        else if (tray_lvl < TRAY_OPEN_LIMIT) begin
          if (interval_due(cfg_m.tray_step_ms)) tray_lvl = tray_lvl + 8'd1;
          busy = 1'b1;
        end else begin
          tray_open = 1'b1;
          end_motion();
        end
      end
      FUNC_TRAY_CLOSE: begin
        if (settle_pending(GRP_TRAY)) busy = 1'b1;
        else if (tray_lvl > TRAY_CLOSE_LIMIT) begin
          if (interval_due(cfg_m.tray_step_ms)) tray_lvl = tray_lvl - 8'd1;
          busy = 1'b1;
        end else begin
          tray_open = 1'b0;
          end_motion();
        end
      end
      FUNC_ARM_MOVE: begin
        if (settle_pending(GRP_ARM)) busy = 1'b1;
        else begin
          // Right level minus target, both in hundredths; a whole count
          // either way means a step is still owed.
          offset_h = int'(arm_r) * int'(HUNDRED) -
                     (pct * int'(ARM_SLOPE_H) + int'(ARM_BASE_H));
          if (offset_h <= -int'(HUNDRED)) begin
            if (interval_due(cfg_m.arm_raise_step_ms)) begin
              arm_r = arm_r + 8'd1;
              arm_l = arm_l - 8'd1;
            end
            busy = 1'b1;
          end else if (offset_h >= int'(HUNDRED)) begin
            if (interval_due(cfg_m.arm_lower_step_ms)) begin
              arm_r = arm_r - 8'd1;
              arm_l = arm_l + 8'd1;
            end
            busy = 1'b1;
          end else begin
            end_motion();
          end
        end
      end
      default: begin
        if (ms_count != MS_MAX) ms_count = ms_count + 16'd1;
      end
    endcase
    r.busy      = busy;
    r.grip      = grip_lvl;
    r.tray      = tray_lvl;
    r.arm_right = arm_r;
    r.arm_left  = arm_l;
    r.power     = pwr;
    return r;
  endfunction

  // Ticks to leave between polls of a motion: around the current interval,
  // clipped so that large settings do not stretch the run.
  function automatic int motion_wait(input func_t op);
    int span;
    if (settling) span = cfg_m.settle_ms;
    else begin
      case (op)
        FUNC_GRIP_OPEN:  span = cfg_m.grip_open_step_ms;
        FUNC_GRIP_CLOSE: span = cfg_m.grip_close_step_ms;
        FUNC_TRAY_OPEN,
        FUNC_TRAY_CLOSE: span = cfg_m.tray_step_ms;
        FUNC_ARM_MOVE:   span = (cfg_m.arm_raise_step_ms > cfg_m.arm_lower_step_ms) ?
                                cfg_m.arm_raise_step_ms : cfg_m.arm_lower_step_ms;
        default:         span = 0;
      endcase
    end
    return (span > 64) ? 65 : span + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Drive on the falling edge, sample the handshake on the
  // rising edge. Requests go out in bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  task automatic send_request(input func_t op, input logic [6:0] pct);
    result_t r;
    int      gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    req_valid          <= 1'b1;
    func               <= op;
    arm_target_percent <= pct;
    // Hold the request until the block takes it.
    do @(posedge clk); while (req_stall);
    r = servo_step(op, pct);
    servo_outputs_q.push_back(r);
    last_busy = r.busy;
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(FUNC_MS_TICK, 7'($urandom_range(0, 127)));
  endtask

  // Drop valid and hold off until every predicted result has come back,
  // then let the pipeline go quiet.
  task automatic wait_all_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (servo_outputs_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SETTLE_MS:       cfg_m.settle_ms          = value;
      REG_GRIP_OPEN_STEP:  cfg_m.grip_open_step_ms  = value;
      REG_GRIP_CLOSE_STEP: cfg_m.grip_close_step_ms = value;
      REG_TRAY_STEP:       cfg_m.tray_step_ms       = value;
      REG_ARM_RAISE_STEP:  cfg_m.arm_raise_step_ms  = value;
      REG_ARM_LOWER_STEP:  cfg_m.arm_lower_step_ms  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] settle, input logic [15:0] grip_open,
                            input logic [15:0] grip_close, input logic [15:0] tray,
                            input logic [15:0] raise, input logic [15:0] lower);
    write_reg(REG_SETTLE_MS,       settle);
    write_reg(REG_GRIP_OPEN_STEP,  grip_open);
    write_reg(REG_GRIP_CLOSE_STEP, grip_close);
    write_reg(REG_TRAY_STEP,       tray);
    write_reg(REG_ARM_RAISE_STEP,  raise);
    write_reg(REG_ARM_LOWER_STEP,  lower);
  endtask

  // Poll one motion, ticking between polls, until it reports done.
  task automatic run_motion(input func_t op, input logic [6:0] pct);
    int polls;
    polls = 0;
    send_request(op, pct);
    while (last_busy && polls < MAX_POLLS) begin
      send_ticks($urandom_range(0, motion_wait(op)));
      send_request(op, pct);
      polls++;
    end
  endtask

  // One tick short of the interval the poll must not step; on the interval it must.
  task automatic step_boundary(input func_t op, input logic [6:0] pct,
                               input logic [15:0] interval);
    send_ticks(int'(interval) - 1);
    send_request(op, pct);
    send_ticks(1);
    send_request(op, pct);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall on a pattern of its own, check every accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) stall_left--;
    else begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end
    case (stall_mode)
      0:       rsp_stall <= 1'b0;                          // free running
      1:       rsp_stall <= ($urandom_range(0, 3) == 0);   // light back-pressure
      2:       rsp_stall <= ($urandom_range(0, 3) != 0);   // heavy back-pressure
      default: rsp_stall <= ((stall_left % 8) < 3);        // periodic stall
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (servo_outputs_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual busy=%0d grip=%0d",
                 $time, busy_res, grip_compare);
      end else begin
        want = servo_outputs_q.pop_front();
        check_field("busy_res",          32'(want.busy),      32'(busy_res));
        check_field("grip_compare",      32'(want.grip),      32'(grip_compare));
        check_field("tray_compare",      32'(want.tray),      32'(tray_compare));
        check_field("arm_right_compare", 32'(want.arm_right), 32'(arm_right_compare));
        check_field("arm_left_compare",  32'(want.arm_left),  32'(arm_left_compare));
        check_field("servo_power",       32'(want.power),     32'(servo_power));
      end
    end
  end

  // Watchdog: any accepted request, result or register write resets the count.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("servo_slew_sequencer_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timings: settle exactly at 300 ticks, then each step interval at its
  // reset value, hitting every motion but tray close and both arm directions.
  task automatic test_reset_timing();
    send_request(FUNC_GRIP_OPEN, 7'd0);              // load compare, start settling
    send_ticks(int'(SETTLE_RESET) - 1);
    send_request(FUNC_GRIP_CLOSE, 7'd0);             // one tick short: still settling
    send_ticks(1);
    send_request(FUNC_GRIP_CLOSE, 7'd0);             // settled, power comes on
    step_boundary(FUNC_GRIP_CLOSE, 7'd0,   GRIP_CLOSE_RESET);
    step_boundary(FUNC_GRIP_OPEN,  7'd0,   GRIP_OPEN_RESET);
    step_boundary(FUNC_TRAY_OPEN,  7'd0,   TRAY_STEP_RESET);
    step_boundary(FUNC_ARM_MOVE,   7'd0,   ARM_LOWER_RESET);
    step_boundary(FUNC_ARM_MOVE,   PCT_MAX, ARM_RAISE_RESET);
    send_request(FUNC_ARM_MOVE, PCT_MAX);            // on target: done, power drops
  endtask

  // All intervals zero: settle and step on the very same poll. Also covers
  // percent above range, held power and the field extremes.
  task automatic test_zero_intervals();
    set_timing('0, '0, '0, '0, '0, '0);
    send_request(FUNC_GRIP_CLOSE, 7'd0);
    send_request(FUNC_GRIP_CLOSE, 7'd0);
    send_request(FUNC_GRIP_OPEN,  7'h7F);            // percent ignored off the arm
    send_request(FUNC_TRAY_OPEN,  7'd0);
    send_request(FUNC_TRAY_CLOSE, 7'd0);
    send_request(FUNC_ARM_MOVE,   7'd127);           // saturates to full scale
    send_request(FUNC_ARM_MOVE,   7'd101);
    send_request(FUNC_ARM_MOVE,   7'd0);
    send_request(FUNC_ARM_MOVE,   7'd0);
    send_request(FUNC_POWER_ON,   7'h7F);
    send_request(FUNC_ARM_MOVE,   PCT_MAX);
    send_request(FUNC_ARM_MOVE,   PCT_MAX);
    send_request(FUNC_MS_TICK,    7'h7F);
    send_request(FUNC_ARM_MOVE,   7'd127);           // done with power held
    send_request(FUNC_POWER_OFF,  7'd0);
    send_request(FUNC_MS_TICK,    7'd0);
    // Leave the sequencer back in its settle phase for the next test.
    run_motion(FUNC_GRIP_OPEN, 7'd0);
  endtask

  // Mostly complete motions with random targets and tick spacing under a
  // series of timing settings; the rest is power requests, noise, motions
  // abandoned part way and waits for all results to come back.
  task automatic test_random_motion();
    int    stop_at;
    int    phase_end;
    int    pick;
    func_t op;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        set_timing(16'($urandom_range(0, 60)), 16'($urandom_range(0, 25)),
                   16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)),
                   16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)));
      else
        set_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
      phase_end = items_sent + $urandom_range(120, 260);
      while (items_sent < phase_end && items_sent < stop_at) begin
        pick = $urandom_range(0, 19);
        op   = func_t'($urandom_range(FUNC_GRIP_OPEN, FUNC_ARM_MOVE));
        if (pick < 13) begin
          run_motion(op, 7'($urandom_range(0, 127)));
        end else if (pick < 15) begin
          send_request($urandom_range(0, 1) ? FUNC_POWER_ON : FUNC_POWER_OFF,
                       7'($urandom_range(0, 127)));
        end else if (pick < 17) begin
          repeat ($urandom_range(1, 8))
            send_request(func_t'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end else if (pick < 19) begin
          // Abandon a motion part way through.
          repeat ($urandom_range(1, 5)) begin
            send_request(op, 7'($urandom_range(0, 127)));
            send_ticks($urandom_range(0, 3));
          end
        end else begin
          wait_all_results();
        end
      end
    end
  endtask

  initial begin
    reset_servo_model();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_reset_timing();
    test_zero_intervals();
    test_random_motion();
    wait_all_results();
    if (errors == 0) begin
      $display("servo_slew_sequencer_top verification clean");
    end else begin
      $display("servo_slew_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* servo_slew_sequencer_top.f */
hdl/sss_pkg.sv
hdl/sss_core.sv
hdl/servo_slew_sequencer_top.sv
tb/tb_servo_slew_sequencer_top.sv
